// ----- hw/rtl/dsss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared store package
// Types, field widths and operation codes shared by the front, back and top.
// ----------------------------------------------------------------------------
package dsss_pkg;

   localparam int DEPTH_DEF = 256;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 9;
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;
   localparam int FSLOT_W   = 8;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = 1;

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

   localparam logic [ST_W-1:0] ST_OK       = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic                     which_stack;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic signed [DATA_W-1:0] data;
      logic [FSLOT_W-1:0]       found_slot;
      logic [CNT_W-1:0]         stack_size;
      logic                     is_empty;
      logic                     is_full;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_PEEK   = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_SEARCH = 3'd4,
      CMD_NOP    = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic              sel_b;
      logic [DATA_W-1:0] value;
   } cmd_type;

endpackage

// ----- hw/rtl/dsss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dsss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack front end
// Accepts request words, decodes the operation and holds them in a short queue.
// ----------------------------------------------------------------------------
module dsss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dsss_pkg::req_type req_word,
   output logic              busy,
   output logic              cmd_valid,
   output dsss_pkg::cmd_type cmd,
   input  logic              cmd_ready
);

   import dsss_pkg::*;

   cmd_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]    fill_ff, fill_in;
   logic                accept;
   logic                take;
   cmd_type             cmd_in;

   always_comb begin
      case (req_word.op)
         OP_PUSH:   cmd_in.kind = CMD_PUSH;
         OP_POP:    cmd_in.kind = CMD_POP;
         OP_PEEK:   cmd_in.kind = CMD_PEEK;
         OP_CLEAR:  cmd_in.kind = CMD_CLEAR;
         OP_SEARCH: cmd_in.kind = CMD_SEARCH;
         default:   cmd_in.kind = CMD_NOP;
      endcase
      cmd_in.sel_b = req_word.which_stack;
      cmd_in.value = req_word.value;
   end

   assign busy      = (fill_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign accept    = start && !busy;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign take      = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept && !take) begin
         fill_in = fill_ff + (Q_PTR_W+1)'(1);
      end else if (take && !accept) begin
         fill_in = fill_ff - (Q_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- hw/rtl/dsss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack back end
// Holds the stack counts and capacity, executes commands on the shared store
// and registers one result word per command.
// ----------------------------------------------------------------------------
module dsss_back #(
   parameter int DEPTH = dsss_pkg::DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  dsss_pkg::cmd_type            cmd,
   output logic                         cmd_ready,
   input  logic                         csr_write,
   input  logic [dsss_pkg::CNT_W-1:0]   csr_data,
   output logic                         idle,
   output logic                         rsp_valid,
   output dsss_pkg::rsp_type            rsp_word
);

   import dsss_pkg::*;

   localparam int AW        = $clog2(DEPTH);
   localparam int SLOT_W    = (AW > CNT_W) ? AW : CNT_W;
   localparam int CAP_MAX   = (DEPTH < 511) ? DEPTH : 511;
   localparam int CAP_RESET = (DEPTH < 256) ? DEPTH : 256;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_READ = 3'b010,
      BK_SCAN = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_a_ff, cnt_a_in;
   logic [CNT_W-1:0]  cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic              sel_ff, sel_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]  scan_slot_ff, scan_slot_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [CNT_W-1:0]  wr_slot;
   logic              rd_en;
   logic [CNT_W-1:0]  rd_slot;
   logic [DATA_W-1:0] rd_data;

   logic [CNT_W-1:0]  cur_cnt;
   logic [CNT_W-1:0]  top_slot;
   logic [CNT_W-1:0]  push_slot;
   logic [CNT_W-1:0]  next_slot;
   logic [CNT_W:0]    cnt_sum;
   logic [CNT_W:0]    cnt_sum_next;
   logic              now_full;
   logic [ST_W-1:0]   status;
   logic [DATA_W-1:0] data;
   logic [CNT_W-1:0]  hit_slot;
   logic [CNT_W-1:0]  rsp_cnt;
   logic [CNT_W-1:0]  cap_clamped;

   function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] s);
      logic [SLOT_W-1:0] w;
      w = SLOT_W'(s);
      return w[AW-1:0];
   endfunction

   dsss_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (to_addr(wr_slot)),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (to_addr(rd_slot)),
      .rd_data (rd_data)
   );

   always_comb begin
      cap_clamped = csr_data;
      if (csr_data == '0) begin
         cap_clamped = CNT_W'(1);
      end else if (int'(csr_data) > DEPTH) begin
         cap_clamped = CNT_W'(CAP_MAX);
      end
   end

   assign cnt_sum   = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign now_full  = (cnt_sum >= {1'b0, cap_ff});
   assign cur_cnt   = cmd.sel_b ? cnt_b_ff : cnt_a_ff;
   // Stack B's top sits at capacity - count_b, stack A's at count_a - 1.
   assign top_slot  = cmd.sel_b ? (cap_ff - cnt_b_ff) : (cnt_a_ff - CNT_W'(1));
   assign push_slot = cmd.sel_b ? (cap_ff - CNT_W'(1) - cnt_b_ff) : cnt_a_ff;
   // A search walks from the top toward the bottom of the selected stack.
   assign next_slot = sel_ff ? (scan_slot_ff + CNT_W'(1)) : (scan_slot_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      cap_in       = cap_ff;
      sel_in       = sel_ff;
      key_in       = key_ff;
      scan_slot_in = scan_slot_ff;
      rem_in       = rem_ff;
      cmd_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_slot      = push_slot;
      rd_en        = 1'b0;
      rd_slot      = top_slot;
      rsp_valid_in = 1'b0;
      status       = ST_OK;
      data         = '0;
      hit_slot     = '0;

      case (state_ff)
         BK_IDLE: begin
            if (csr_write) begin
               cap_in   = cap_clamped;
               cnt_a_in = '0;
               cnt_b_in = '0;
            end else if (cmd_valid) begin
               cmd_ready = 1'b1;
               sel_in    = cmd.sel_b;
               case (cmd.kind)
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (now_full) begin
                        status = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        if (cmd.sel_b) begin
                           cnt_b_in = cnt_b_ff + CNT_W'(1);
                        end else begin
                           cnt_a_in = cnt_a_ff + CNT_W'(1);
                        end
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (cur_cnt == '0) begin
                        rsp_valid_in = 1'b1;
                        status       = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = BK_READ;
                        if (cmd.kind == CMD_POP) begin
                           if (cmd.sel_b) begin
                              cnt_b_in = cnt_b_ff - CNT_W'(1);
                           end else begin
                              cnt_a_in = cnt_a_ff - CNT_W'(1);
                           end
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     if (cmd.sel_b) begin
                        cnt_b_in = '0;
                     end else begin
                        cnt_a_in = '0;
                     end
                  end
                  CMD_SEARCH: begin
                     if (cur_cnt == '0) begin
                        rsp_valid_in = 1'b1;
                        status       = ST_NOTFOUND;
                     end else begin
                        rd_en        = 1'b1;
                        key_in       = cmd.value;
                        scan_slot_in = top_slot;
                        rem_in       = cur_cnt - CNT_W'(1);
                        state_in     = BK_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            rsp_valid_in = 1'b1;
            data         = rd_data;
            state_in     = BK_IDLE;
         end
         BK_SCAN: begin
            // rd_data holds the entry at scan_slot_ff, read in the previous cycle.
            if (rd_data == key_ff) begin
               rsp_valid_in = 1'b1;
               hit_slot     = scan_slot_ff;
               state_in     = BK_IDLE;
            end else if (rem_ff == '0) begin
               rsp_valid_in = 1'b1;
               status       = ST_NOTFOUND;
               state_in     = BK_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_slot      = next_slot;
               scan_slot_in = next_slot;
               rem_in       = rem_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      cnt_sum_next          = {1'b0, cnt_a_in} + {1'b0, cnt_b_in};
      rsp_cnt               = sel_in ? cnt_b_in : cnt_a_in;
      rsp_in.status         = status;
      rsp_in.data           = data;
      rsp_in.found_slot     = hit_slot[FSLOT_W-1:0];
      rsp_in.stack_size     = rsp_cnt;
      rsp_in.is_empty       = (rsp_cnt == '0);
      rsp_in.is_full        = (cnt_sum_next >= {1'b0, cap_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         cap_ff       <= CNT_W'(CAP_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff       <= sel_in;
      key_ff       <= key_in;
      scan_slot_ff <= scan_slot_in;
      rem_ff       <= rem_in;
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign idle      = (state_ff == BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ----- hw/rtl/dual_stack_shared_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared store
// Two stacks in one word store; A grows up from slot 0, B grows down from
// slot capacity-1.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each request yields exactly one
// result word, shown for a single cycle with rsp_valid, and the receiver
// cannot hold it off. The back end answers a push, clear, an unused code, or
// a refused push, pop, peek or search from its idle state; a pop or peek goes
// through a read state, as the store has one registered read port; and a
// search goes through a scan state that compares entries, one per cycle, from
// the top of the stack down. The store needs no clearing after reset. A
// capacity write empties both stacks and is taken only while the block has
// no work pending.
module dual_stack_shared_store #(
   parameter int DEPTH = dsss_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dsss_pkg::req_type          req_word,
   output logic                       rsp_valid,
   output dsss_pkg::rsp_type          rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [dsss_pkg::CNT_W-1:0] csr_data
);

   import dsss_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;
   logic    back_idle;
   logic    csr_write;

   assign csr_ready = back_idle && !cmd_valid;
   assign csr_write = csr_valid && csr_ready;

   dsss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_word  (req_word),
      .busy      (busy),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   dsss_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .idle      (back_idle),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // A refused push means the store was full, and it stays full.
   a_full_refusal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.is_full)
      else $error("push refused while store not full");

   // Pop or peek on an empty stack leaves it empty.
   a_empty_refusal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_EMPTY |-> rsp_word.is_empty)
      else $error("empty status on a non-empty stack");

   // The back end takes a command only between operations.
   a_take_when_idle : assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |-> back_idle)
      else $error("command taken while back end busy");

   // A full queue always offers a command to the back end.
   a_busy_has_cmd : assert property (@(posedge clock) disable iff (reset)
      busy |-> cmd_valid)
      else $error("busy with an empty queue");

endmodule
